>>> rtl/tlg_pkg.sv
package tlg_pkg;

   // Default grid size.
   localparam int DEF_GRID_WIDTH  = 8;
   localparam int DEF_GRID_HEIGHT = 8;

   // Fixed field widths.
   localparam int CMD_W   = 2;
   localparam int INDEX_W = 3;
   localparam int BITS_W  = 8;
   localparam int DATA_W  = 8;
   localparam int POP_W   = 7;
   localparam int LIMIT_W = 8;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_STEP = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_READ = CMD_W'(2);

   localparam logic [LIMIT_W-1:0] STAG_LIMIT_RESET = LIMIT_W'(20);
   localparam logic [POP_W-1:0]   POP_MAX          = POP_W'(127);
   localparam logic [LIMIT_W-1:0] STAG_MAX         = LIMIT_W'(255);

   // Controls for the rotating column store.
   typedef struct packed {
      logic shift;
      logic first;
      logic last;
      logic advance;
      logic load_here;
   } ring_ctrl_type;

   // Controls for the population counter.
   typedef struct packed {
      logic clear;
      logic accumulate;
      logic sum;
   } pop_ctrl_type;

endpackage

>>> rtl/toroidal_life_generation_core.sv
// Toroidal Life generation core. The grid of GRID_WIDTH columns by
// GRID_HEIGHT rows wraps at every edge and is kept as a ring of column
// registers that rotates one column per clock while it scans or updates.
// Every transaction first rotates the whole ring once to count live cells
// per row and to load or read the addressed column, then shifts the row
// counts into a total, then, for a step, decides on stagnation and restart.
// A step that advances the grid rotates the ring a second time, computing
// one new column per cycle from its two neighbors with one B3/S23 cell per
// row. A finished result waits in the response register while the next
// request is taken. The reported population is that of the grid before the
// transaction, saturated at 127. The stagnation limit may be written only
// while the core is idle.
module toroidal_life_generation_core #(
   parameter int GRID_WIDTH  = tlg_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = tlg_pkg::DEF_GRID_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tlg_pkg::CMD_W-1:0]     req_command,
   input  logic [tlg_pkg::INDEX_W-1:0]   req_column_index,
   input  logic [tlg_pkg::BITS_W-1:0]    req_column_bits,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tlg_pkg::DATA_W-1:0]    rsp_column_data,
   output logic [tlg_pkg::POP_W-1:0]     rsp_population,
   output logic                          rsp_restart_needed,
   input  logic                          csr_wr_en,
   input  logic [tlg_pkg::LIMIT_W-1:0]   csr_wr_data
);
   import tlg_pkg::*;

   localparam int MAX_WH = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
   localparam int CNT_W  = $clog2(MAX_WH);
   localparam int TOT_W  = $clog2(GRID_WIDTH * GRID_HEIGHT + 1);
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int PW     = (TOT_W > POP_W) ? TOT_W : POP_W;
   localparam int COL_W  = (GRID_HEIGHT > BITS_W) ? GRID_HEIGHT : BITS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SUM,
      ST_DECIDE,
      ST_UPDATE,
      ST_REPLY
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic [BITS_W-1:0]      bits_ff, bits_in;
   logic [DATA_W-1:0]      read_data_ff, read_data_in;
   logic [POP_W-1:0]       pop_ff, pop_in;
   logic                   restart_ff, restart_in;
   logic [POP_W-1:0]       prev_pop_ff, prev_pop_in;
   logic                   prev_valid_ff, prev_valid_in;
   logic [LIMIT_W-1:0]     stag_ff, stag_in;
   logic [LIMIT_W-1:0]     limit_ff, limit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [POP_W-1:0]       rsp_pop_ff, rsp_pop_in;
   logic                   rsp_restart_ff, rsp_restart_in;

   ring_ctrl_type          ring_ctrl;
   pop_ctrl_type           pop_ctrl;
   logic [GRID_HEIGHT-1:0] head_column;
   logic [GRID_HEIGHT-1:0] load_column;
   logic [COL_W-1:0]       bits_wide, head_wide;
   logic [TOT_W-1:0]       total;
   logic [PW-1:0]          total_wide;
   logic [POP_W-1:0]       pop_sat;
   logic [LIMIT_W-1:0]     stag_next;
   logic                   restart_now;
   logic                   last_column, last_row, index_hit, req_take;

   // Loaded bits above the grid height are dropped; a column shorter than
   // the output field reads back zero-extended.
   assign bits_wide   = COL_W'(bits_ff);
   assign load_column = bits_wide[GRID_HEIGHT-1:0];
   assign head_wide   = COL_W'(head_column);

   assign last_column = (count_ff == CNT_W'(GRID_WIDTH - 1));
   assign last_row    = (count_ff == CNT_W'(GRID_HEIGHT - 1));
   // The ring position never reaches GRID_WIDTH, so an index beyond the
   // grid never matches: such a load is ignored and such a read gives zero.
   assign index_hit   = (CMP_W'(count_ff) == CMP_W'(index_ff));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign total_wide = PW'(total);
   assign pop_sat    = (total_wide > PW'(POP_MAX)) ? POP_MAX : total_wide[POP_W-1:0];

   // A repeated population extends the stagnation run; anything else
   // breaks it.
   always_comb begin
      if (prev_valid_ff && (pop_sat == prev_pop_ff)) begin
         stag_next = (stag_ff == STAG_MAX) ? stag_ff : stag_ff + LIMIT_W'(1);
      end else begin
         stag_next = '0;
      end
   end
   assign restart_now = (pop_sat == '0) || (stag_next > limit_ff);

   always_comb begin
      ring_ctrl.shift     = (state_ff == ST_SCAN) || (state_ff == ST_UPDATE);
      ring_ctrl.first     = (count_ff == '0);
      ring_ctrl.last      = last_column;
      ring_ctrl.advance   = (state_ff == ST_UPDATE);
      ring_ctrl.load_here = (state_ff == ST_SCAN) && (cmd_ff == CMD_LOAD) && index_hit;
      pop_ctrl.clear      = req_take;
      pop_ctrl.accumulate = (state_ff == ST_SCAN);
      pop_ctrl.sum        = (state_ff == ST_SUM);
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cmd_in         = cmd_ff;
      index_in       = index_ff;
      bits_in        = bits_ff;
      read_data_in   = read_data_ff;
      pop_in         = pop_ff;
      restart_in     = restart_ff;
      prev_pop_in    = prev_pop_ff;
      prev_valid_in  = prev_valid_ff;
      stag_in        = stag_ff;
      limit_in       = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rsp_pop_in     = rsp_pop_ff;
      rsp_restart_in = rsp_restart_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_command;
               index_in     = req_column_index;
               bits_in      = req_column_bits;
               read_data_in = '0;
               count_in     = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((cmd_ff == CMD_READ) && index_hit) begin
               read_data_in = head_wide[DATA_W-1:0];
            end
            if (last_column) begin
               count_in = '0;
               state_in = ST_SUM;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_SUM: begin
            if (last_row) begin
               count_in = '0;
               state_in = ST_DECIDE;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_DECIDE: begin
            pop_in     = pop_sat;
            restart_in = 1'b0;
            state_in   = ST_REPLY;
            if (cmd_ff == CMD_STEP) begin
               prev_pop_in = pop_sat;
               if (restart_now) begin
                  restart_in    = 1'b1;
                  prev_valid_in = 1'b0;
                  stag_in       = '0;
               end else begin
                  prev_valid_in = 1'b1;
                  stag_in       = stag_next;
                  state_in      = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (last_column) begin
               count_in = '0;
               state_in = ST_REPLY;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = read_data_ff;
               rsp_pop_in     = pop_ff;
               rsp_restart_in = restart_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         prev_pop_ff   <= '0;
         prev_valid_ff <= 1'b0;
         stag_ff       <= '0;
         limit_ff      <= STAG_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         prev_pop_ff   <= prev_pop_in;
         prev_valid_ff <= prev_valid_in;
         stag_ff       <= stag_in;
         limit_ff      <= limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      index_ff       <= index_in;
      bits_ff        <= bits_in;
      read_data_ff   <= read_data_in;
      pop_ff         <= pop_in;
      restart_ff     <= restart_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_pop_ff     <= rsp_pop_in;
      rsp_restart_ff <= rsp_restart_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_data    = rsp_data_ff;
   assign rsp_population     = rsp_pop_ff;
   assign rsp_restart_needed = rsp_restart_ff;

   tlg_column_ring #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .ring_ctrl   (ring_ctrl),
      .load_column (load_column),
      .head_column (head_column)
   );

   tlg_pop_counter #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_pop (
      .clock       (clock),
      .pop_ctrl    (pop_ctrl),
      .head_column (head_column),
      .total       (total)
   );

   // An accepted transaction always starts with a pass around the ring.
   a_accept_starts_scan : assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_SCAN)
      else $error("accepted transaction did not start the column scan");

   // The grid only advances right after a step that left history valid.
   a_update_has_history : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> prev_valid_ff)
      else $error("grid advancing without a recorded generation");

   // A new response appears only out of the reply state.
   a_response_from_reply : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("response raised outside the reply state");

   // A restart comes only from a step, which never returns column data.
   a_restart_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_restart_ff |-> rsp_data_ff == '0)
      else $error("restart response carries column data");

endmodule

>>> rtl/tlg_column_ring.sv
module tlg_column_ring #(
   parameter int GRID_WIDTH  = tlg_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = tlg_pkg::DEF_GRID_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tlg_pkg::ring_ctrl_type  ring_ctrl,
   input  logic [GRID_HEIGHT-1:0]  load_column,
   output logic [GRID_HEIGHT-1:0]  head_column
);
   import tlg_pkg::*;

   logic [GRID_HEIGHT-1:0] column_ff [GRID_WIDTH];
   logic [GRID_HEIGHT-1:0] column_in [GRID_WIDTH];
   logic [GRID_HEIGHT-1:0] left_ff, left_in;
   logic [GRID_HEIGHT-1:0] first_ff, first_in;
   logic [GRID_HEIGHT-1:0] left_column, right_column, fresh_column, tail_column;

   assign head_column = column_ff[0];

   // The column that left the head last cycle is the left neighbor; at the
   // first position the left neighbor is still sitting at the tail. The
   // original first column is kept aside as the right neighbor of the last.
   assign left_column  = ring_ctrl.first ? column_ff[GRID_WIDTH-1] : left_ff;
   assign right_column = ring_ctrl.last ? first_ff : column_ff[1];

   for (genvar y = 0; y < GRID_HEIGHT; y++) begin : g_cell
      localparam int YU = (y + GRID_HEIGHT - 1) % GRID_HEIGHT;
      localparam int YD = (y + 1) % GRID_HEIGHT;
      logic [3:0] neighbors;
      assign neighbors = 4'(left_column[YU]) + 4'(left_column[y]) + 4'(left_column[YD])
                       + 4'(head_column[YU]) + 4'(head_column[YD])
                       + 4'(right_column[YU]) + 4'(right_column[y])
                       + 4'(right_column[YD]);
      assign fresh_column[y] = head_column[y] ? (neighbors == 4'd2 || neighbors == 4'd3)
                                              : (neighbors == 4'd3);
   end

   always_comb begin
      if (ring_ctrl.advance) begin
         tail_column = fresh_column;
      end else if (ring_ctrl.load_here) begin
         tail_column = load_column;
      end else begin
         tail_column = head_column;
      end
      for (int i = 0; i < GRID_WIDTH; i++) begin
         column_in[i] = column_ff[i];
      end
      left_in  = left_ff;
      first_in = first_ff;
      if (ring_ctrl.shift) begin
         for (int i = 0; i < GRID_WIDTH - 1; i++) begin
            column_in[i] = column_ff[i+1];
         end
         column_in[GRID_WIDTH-1] = tail_column;
         left_in = head_column;
         if (ring_ctrl.first) begin
            first_in = head_column;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRID_WIDTH; i++) begin
            column_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < GRID_WIDTH; i++) begin
            column_ff[i] <= column_in[i];
         end
      end
      left_ff  <= left_in;
      first_ff <= first_in;
   end

endmodule

>>> rtl/tlg_pop_counter.sv
module tlg_pop_counter #(
   parameter int GRID_WIDTH  = tlg_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = tlg_pkg::DEF_GRID_HEIGHT
) (
   input  logic                                          clock,
   input  tlg_pkg::pop_ctrl_type                         pop_ctrl,
   input  logic [GRID_HEIGHT-1:0]                        head_column,
   output logic [$clog2(GRID_WIDTH*GRID_HEIGHT+1)-1:0]   total
);
   import tlg_pkg::*;

   localparam int ROW_W = $clog2(GRID_WIDTH + 1);
   localparam int TOT_W = $clog2(GRID_WIDTH * GRID_HEIGHT + 1);

   logic [ROW_W-1:0] row_ff [GRID_HEIGHT];
   logic [ROW_W-1:0] row_in [GRID_HEIGHT];
   logic [TOT_W-1:0] total_ff, total_in;

   assign total = total_ff;

   // Each row lane counts one bit per column as the grid rotates past; the
   // lanes are then shifted out one per cycle into the total.
   always_comb begin
      for (int y = 0; y < GRID_HEIGHT; y++) begin
         row_in[y] = row_ff[y];
      end
      total_in = total_ff;
      if (pop_ctrl.clear) begin
         for (int y = 0; y < GRID_HEIGHT; y++) begin
            row_in[y] = '0;
         end
         total_in = '0;
      end else if (pop_ctrl.accumulate) begin
         for (int y = 0; y < GRID_HEIGHT; y++) begin
            row_in[y] = row_ff[y] + ROW_W'(head_column[y]);
         end
      end else if (pop_ctrl.sum) begin
         for (int y = 0; y < GRID_HEIGHT - 1; y++) begin
            row_in[y] = row_ff[y+1];
         end
         row_in[GRID_HEIGHT-1] = '0;
         total_in = total_ff + TOT_W'(row_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      for (int y = 0; y < GRID_HEIGHT; y++) begin
         row_ff[y] <= row_in[y];
      end
      total_ff <= total_in;
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the toroidal Life generation core. Commands go in
// through the req_ channel, one reply per command comes back on the rsp_
// channel, and a behavioral model of the grid inside this module predicts
// every reply as its command is accepted. Replies are compared field by field
// in order.
module testbench;
   import tlg_pkg::*;

   localparam int GRID_W = DEF_GRID_WIDTH;
   localparam int GRID_H = DEF_GRID_HEIGHT;

   // The spare command value has no function in the core, but the field allows it.
   localparam logic [CMD_W-1:0] CMD_RESERVED = CMD_W'(3);

   // A step that advances the grid is the slowest transaction. The tail wait
   // covers one of those plus a margin.
   localparam int DRAIN_CYCLES   = 2 * GRID_W + GRID_H + 16;
   // Sized for about 700 transactions, each no slower than an advancing step,
   // roughly doubled by random idling on both sides, plus the long hold-off,
   // and then taken several times over.
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int IDLE_PERCENT   = 31;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [INDEX_W-1:0] column_index;
      logic [BITS_W-1:0]  column_bits;
   } life_command_type;

   typedef struct packed {
      logic [DATA_W-1:0] column_data;
      logic [POP_W-1:0]  population;
      logic              restart_needed;
   } life_response_type;

   // Every input of the core holds a known value from time zero.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command = CMD_LOAD;
   logic [INDEX_W-1:0]  req_column_index = '0;
   logic [BITS_W-1:0]   req_column_bits = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_column_data;
   logic [POP_W-1:0]    rsp_population;
   logic                rsp_restart_needed;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;

   life_command_type  command_queue[$];
   life_response_type expected_responses[$];

   int  idle_percent = IDLE_PERCENT;
   int  rsp_hold_left = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  req_taken = 1'b0;

   // Shadow copy of the core's state, held at the core's widths. It starts
   // from the reset values, since reset is applied only once.
   logic [GRID_H-1:0]  life_grid [GRID_W] = '{default: '0};
   logic [POP_W-1:0]   last_population = '0;
   logic               last_population_valid = 1'b0;
   logic [LIMIT_W-1:0] stagnation_count = '0;
   logic [LIMIT_W-1:0] stagnation_limit = STAG_LIMIT_RESET;

   toroidal_life_generation_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_column_index   (req_column_index),
      .req_column_bits    (req_column_bits),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_column_data    (rsp_column_data),
      .rsp_population     (rsp_population),
      .rsp_restart_needed (rsp_restart_needed),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Grid prediction
   // ---------------------------------------------------------------------

   // The live cell count saturates at POP_MAX, which an 8 by 8 grid never reaches.
   function automatic logic [POP_W-1:0] grid_population();
      int total;
      total = 0;
      for (int x = 0; x < GRID_W; x++) begin
         total += $countones(life_grid[x]);
      end
      return (total > int'(POP_MAX)) ? POP_MAX : POP_W'(total);
   endfunction

   // Cell lookup with wraparound on both axes, so that the offsets -1 and +1 are legal.
   function automatic int cell_alive(int x, int y);
      return int'(life_grid[(x + GRID_W) % GRID_W][(y + GRID_H) % GRID_H]);
   endfunction

   // One B3/S23 generation, with every cell computed from the old grid.
   task automatic advance_life_grid();
      logic [GRID_H-1:0] fresh [GRID_W];
      int neighbors;
      for (int x = 0; x < GRID_W; x++) begin
         for (int y = 0; y < GRID_H; y++) begin
            neighbors = 0;
            for (int dx = -1; dx <= 1; dx++) begin
               for (int dy = -1; dy <= 1; dy++) begin
                  if (dx != 0 || dy != 0) begin
                     neighbors += cell_alive(x + dx, y + dy);
                  end
               end
            end
            fresh[x][y] = (neighbors == 3) || (life_grid[x][y] && neighbors == 2);
         end
      end
      life_grid = fresh;
   endtask

   // Updates the shadow state for one accepted command and gives the reply
   // that the core should send back for it. The population always reflects
   // the grid as it stood before the command.
   task automatic apply_life_command(input life_command_type cmd,
                                     output life_response_type rsp);
      logic [POP_W-1:0] pop;
      pop = grid_population();
      rsp = '0;
      rsp.population = pop;
      case (cmd.command)
         CMD_LOAD: begin
            life_grid[cmd.column_index] = cmd.column_bits[GRID_H-1:0];
         end
         CMD_READ: begin
            rsp.column_data = DATA_W'(life_grid[cmd.column_index]);
         end
         CMD_STEP: begin
            // The stagnation counter runs only while the population stays the
            // same from one step to the next, and it stops at its maximum.
            if (last_population_valid && pop == last_population) begin
               if (stagnation_count != STAG_MAX) begin
                  stagnation_count++;
               end
            end else begin
               stagnation_count = '0;
            end
            last_population = pop;
            last_population_valid = 1'b1;
            // An extinct or stagnant grid is left as it is, and its history is dropped.
            if (pop == '0 || stagnation_count > stagnation_limit) begin
               rsp.restart_needed = 1'b1;
               last_population_valid = 1'b0;
               stagnation_count = '0;
            end else begin
               advance_life_grid();
            end
         end
         default: begin
            // The spare command changes nothing and reports only the population.
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Request driver and acceptance tracking
   // ---------------------------------------------------------------------

   // Inputs change on the falling edge. A new transaction is offered only
   // once the previous one has been accepted, so valid never drops while an
   // item is pending.
   always @(negedge clock) begin
      life_command_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (command_queue.size() != 0 && $urandom_range(99) >= idle_percent) begin
            item = command_queue.pop_front();
            req_command      <= item.command;
            req_column_index <= item.column_index;
            req_column_bits  <= item.column_bits;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Each accepted transaction is predicted at the edge that accepts it.
   // The same process counts cycles and stops a run that hangs.
   always @(posedge clock) begin
      life_response_type predicted;
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("[toroidal_life_generation_core] ERROR");
         $finish;
      end else if (!reset && req_valid && req_ready) begin
         apply_life_command(life_command_type'{command: req_command,
                                               column_index: req_column_index,
                                               column_bits: req_column_bits},
                            predicted);
         expected_responses.push_back(predicted);
         req_taken = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Response side: ready pattern and checker
   // ---------------------------------------------------------------------

   // Ready is random, except during a hold-off. The hold-off is counted here,
   // so the core fills up and stalls its input while requests keep coming.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_percent);
      end
   end

   always @(posedge clock) begin
      life_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response: column_data=%0h population=%0d restart_needed=%0b",
                   rsp_column_data, rsp_population, rsp_restart_needed);
            mismatch_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_column_data !== want.column_data) begin
               $error("column_data: expected %0h, got %0h", want.column_data, rsp_column_data);
               mismatch_count++;
            end
            if (rsp_population !== want.population) begin
               $error("population: expected %0d, got %0d", want.population, rsp_population);
               mismatch_count++;
            end
            if (rsp_restart_needed !== want.restart_needed) begin
               $error("restart_needed: expected %0b, got %0b",
                      want.restart_needed, rsp_restart_needed);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   task automatic queue_command(input logic [CMD_W-1:0] cmd, input int index,
                                input logic [BITS_W-1:0] bits);
      command_queue.push_back(life_command_type'{command: cmd,
                                                 column_index: INDEX_W'(index),
                                                 column_bits: bits});
   endtask

   // Sparse, even or dense column contents, so that random grids die out,
   // settle or keep churning.
   function automatic logic [BITS_W-1:0] random_column(int density);
      case (density)
         0:       return BITS_W'($urandom & $urandom & $urandom);
         1:       return BITS_W'($urandom);
         default: return BITS_W'($urandom | $urandom);
      endcase
   endfunction

   // A run is mostly a full grid load followed by a burst of steps with reads
   // in between. Some runs skip the load and carry on from whatever grid is
   // left, and a share of stray loads and spare commands breaks up the sequence.
   task automatic queue_random_run(input int count);
      int density;
      int pick;
      density = $urandom_range(0, 2);
      if ($urandom_range(99) < 80) begin
         for (int x = 0; x < GRID_W; x++) begin
            queue_command(CMD_LOAD, x, random_column(density));
         end
      end
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            queue_command(CMD_STEP, $urandom_range(GRID_W - 1), BITS_W'($urandom));
         end else if (pick < 85) begin
            queue_command(CMD_READ, $urandom_range(GRID_W - 1), BITS_W'($urandom));
         end else if (pick < 95) begin
            queue_command(CMD_LOAD, $urandom_range(GRID_W - 1), random_column(density));
         end else begin
            queue_command(CMD_RESERVED, $urandom_range(GRID_W - 1), BITS_W'($urandom));
         end
      end
   endtask

   // Waits until every queued transaction has gone in and every reply has come
   // back. The check runs on the rising edge, where the driver's queue is stable.
   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (command_queue.size() != 0 || req_valid || expected_responses.size() != 0);
   endtask

   // The limit is written only while the core is idle, so the shadow copy can
   // take the new value at once.
   task automatic write_stagnation_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      stagnation_limit = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [LIMIT_W-1:0] limit_choices [6];

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, run with the reset value of the limit. It starts on
      // the empty grid, where a read gives zero and a step flags extinction.
      queue_command(CMD_READ, 0, 8'hFF);
      queue_command(CMD_STEP, 7, 8'hFF);
      queue_command(CMD_RESERVED, 7, 8'hFF);
      // Single columns at the edges of the grid, so that the wraparound matters.
      queue_command(CMD_LOAD, 0, 8'hFF);
      queue_command(CMD_LOAD, GRID_W - 1, 8'h80);
      queue_command(CMD_LOAD, 3, 8'h01);
      queue_command(CMD_READ, 0, 8'h00);
      queue_command(CMD_READ, GRID_W - 1, 8'h00);
      queue_command(CMD_READ, 3, 8'h00);
      queue_command(CMD_STEP, 0, 8'h00);
      queue_command(CMD_READ, 0, 8'hFF);
      queue_command(CMD_READ, GRID_W - 1, 8'hFF);
      // On a full grid every cell has eight neighbors, so everything dies.
      // The step after that finds zero population.
      for (int x = 0; x < GRID_W; x++) begin
         queue_command(CMD_LOAD, x, 8'hFF);
      end
      queue_command(CMD_STEP, 0, 8'h00);
      queue_command(CMD_STEP, 0, 8'h00);
      wait_until_drained();

      // With the limit at zero, a blinker restarts on the second step, since
      // its population does not change, and it runs again on the third.
      write_stagnation_limit(LIMIT_W'(0));
      queue_command(CMD_LOAD, 2, 8'h1C);
      queue_command(CMD_STEP, 0, 8'h00);
      queue_command(CMD_STEP, 0, 8'h00);
      queue_command(CMD_STEP, 0, 8'h00);
      queue_command(CMD_READ, 2, 8'h00);
      wait_until_drained();

      // A still life under the highest limit, run without idling on either side.
      // The stagnation counter reaches its maximum and stays there, and it
      // never exceeds the limit.
      idle_percent = 0;
      write_stagnation_limit(LIMIT_W'(255));
      for (int x = 0; x < GRID_W; x++) begin
         queue_command(CMD_LOAD, x, (x == 3 || x == 4) ? 8'h18 : 8'h00);
      end
      for (int k = 0; k < 265; k++) begin
         queue_command(CMD_STEP, k % GRID_W, BITS_W'(k));
         if (k % 50 == 0) begin
            queue_command(CMD_READ, 3, 8'h00);
         end
      end
      wait_until_drained();
      idle_percent = IDLE_PERCENT;

      // Long hold-off on the response side while the request side keeps
      // offering transactions.
      write_stagnation_limit(LIMIT_W'($urandom_range(0, 255)));
      rsp_hold_left = HOLD_OFF_CYCLES;
      queue_random_run(60);
      wait_until_drained();

      // Random runs under a spread of limits. The small limits make
      // oscillators and still lifes restart quickly. In the middle of each
      // setting, the request side stops until every reply has arrived.
      limit_choices = '{LIMIT_W'(1), LIMIT_W'(2), LIMIT_W'(3), STAG_LIMIT_RESET,
                        LIMIT_W'($urandom_range(0, 255)), LIMIT_W'(0)};
      foreach (limit_choices[i]) begin
         write_stagnation_limit(limit_choices[i]);
         queue_random_run(20);
         wait_until_drained();
         queue_random_run(20);
         wait_until_drained();
      end

      // Let any stray reply surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[toroidal_life_generation_core] OK");
      end else begin
         $display("[toroidal_life_generation_core] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/tlg_pkg.sv
rtl/tlg_column_ring.sv
rtl/tlg_pop_counter.sv
rtl/toroidal_life_generation_core.sv
tb/testbench.sv
